// ===== hdl/cbsp_pkg.sv =====
// ----------------------------------------------------------------------------
// cbsp_pkg
// Types and constants shared by the cost-bounded shortest path block.
// ----------------------------------------------------------------------------
package cbsp_pkg;

  localparam int unsigned MaxNodes   = 128;
  localparam int unsigned MaxEdges   = 4096;
  localparam int unsigned CostLimit  = 1024;
  localparam int unsigned WeightBits = 10;

  localparam logic [16:0] DistSat = 17'd131071;

  localparam logic CfgNodeCount = 1'b0;
  localparam logic CfgMaxCost   = 1'b1;

  typedef struct packed {
    logic       edge_present;
    logic [7:0] src_node;
    logic [7:0] dst_node;
    logic [9:0] edge_cost;
    logic [9:0] edge_dist;
    logic       last_edge;
  } in_item_t;

  typedef struct packed {
    logic        reachable;
    logic [16:0] min_distance;
    logic        edge_overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    StLoad,
    StClear,
    StZeroRd,
    StZeroWb,
    StPosRd,
    StPosWb,
    StScanRd,
    StScanWb,
    StOut
  } state_e;

endpackage

// ===== hdl/cbsp_dist_ram.sv =====
// ----------------------------------------------------------------------------
// cbsp_dist_ram
// Distance table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cbsp_dist_ram #(
  parameter int unsigned AW = 17,
  parameter int unsigned DW = 18
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/cost_bounded_shortest_path.sv =====
// ----------------------------------------------------------------------------
// cost_bounded_shortest_path
// Least distance from node 1 to the last node within a total cost bound.
// ----------------------------------------------------------------------------
// Edges load one per cycle into the edge memory. The item marked last
// starts the search, during which the input is stalled. First, rows 0 to the
// cost bound of every node in use are cleared. Then, for each cost layer, the
// zero-cost edges are swept until a sweep changes nothing, followed by one
// sweep over the positive-cost edges. A sweep reads each edge and then its
// source entry; for an edge that applies, it then reads the destination entry
// and writes back a smaller sum. A sweep closes with one more pass through its
// read and write-back states after the last edge. Source and destination reads
// are serialized because the distance table has a single read port. A final
// scan reads the target's layers in turn, and then the result is registered.
// Distances saturate at 131072, which is reported as 131071. The input stays
// stalled until the result is taken.
module cost_bounded_shortest_path #(
  parameter int unsigned MAX_NODES   = cbsp_pkg::MaxNodes,
  parameter int unsigned MAX_EDGES   = cbsp_pkg::MaxEdges,
  parameter int unsigned COST_LIMIT  = cbsp_pkg::CostLimit
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cbsp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cbsp_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [9:0]          cfg_data_i
);

  localparam int unsigned NW  = $clog2(MAX_NODES);
  localparam int unsigned CW  = $clog2(COST_LIMIT);
  localparam int unsigned EW  = $clog2(MAX_EDGES);
  localparam int unsigned WB  = cbsp_pkg::WeightBits;
  localparam int unsigned NCW = ((CW > WB) ? CW : WB) + 1;
  localparam int unsigned AW  = NW + CW;
  localparam int unsigned DW  = 18;
  localparam logic [DW-1:0] Inf = '1;
  localparam logic [DW-1:0] DistCap = DW'(cbsp_pkg::DistSat) + DW'(1);

  typedef struct packed {
    logic [7:0]    src;
    logic [7:0]    dst;
    logic [WB-1:0] cost;
    logic [WB-1:0] weight;
  } edge_t;

  cbsp_pkg::state_e state_q, state_d;
  logic [7:0]  node_count_q;
  logic [9:0]  cost_bound_q;
  logic [EW:0] loaded_q;
  logic        ovf_q;
  logic [EW:0] ei_q, ei_d;
  logic [CW-1:0] layer_q, layer_d;
  logic [NW:0]   cn_q, cn_d;
  logic [CW:0]   cc_q, cc_d;
  logic          changed_q, changed_d;
  logic [DW-1:0] best_q, best_d;
  logic [DW-1:0] from_q, from_d;
  logic          ok_q, ok_d;
  logic          out_valid_q;
  cbsp_pkg::out_item_t out_q;

  edge_t edge_mem [MAX_EDGES];
  edge_t edge_rd_q;

  logic          in_acc;
  logic [NW:0]   n_eff;
  logic [CW-1:0] mc_eff;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != cbsp_pkg::StLoad) || out_valid_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    if (node_count_q == 8'd0) n_eff = (NW+1)'(1);
    else if (32'(node_count_q) > MAX_NODES) n_eff = (NW+1)'(MAX_NODES);
    else n_eff = (NW+1)'(node_count_q);
    if (32'(cost_bound_q) >= COST_LIMIT) mc_eff = CW'(COST_LIMIT - 1);
    else mc_eff = CW'(cost_bound_q);
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.edge_present && (loaded_q < (EW+1)'(MAX_EDGES)))
      edge_mem[loaded_q[EW-1:0]] <= '{in_data_i.src_node, in_data_i.dst_node,
        in_data_i.edge_cost[WB-1:0], in_data_i.edge_dist[WB-1:0]};
    edge_rd_q <= edge_mem[ei_d[EW-1:0]];
  end

  cbsp_dist_ram #(.AW(AW), .DW(DW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // Current-edge decode (edge_rd_q valid in Rd states and beyond).
  logic           e_good;
  logic [NCW-1:0] nc;
  logic [NW-1:0]  sidx, didx;
  assign e_good = (edge_rd_q.src != 8'd0) && ({1'b0, edge_rd_q.src} <= 9'(n_eff)) &&
                  (edge_rd_q.dst != 8'd0) && ({1'b0, edge_rd_q.dst} <= 9'(n_eff));
  assign sidx = NW'(edge_rd_q.src - 8'd1);
  assign didx = NW'(edge_rd_q.dst - 8'd1);
  assign nc   = NCW'(layer_q) + NCW'(edge_rd_q.cost);

  // saturating sum keeps the table entries below the infinity code
  logic [DW:0]   cand_raw;
  logic [DW-1:0] cand;
  assign cand_raw = (DW+1)'(from_q) + (DW+1)'(edge_rd_q.weight);
  assign cand     = (cand_raw > (DW+1)'(DistCap)) ? DistCap : cand_raw[DW-1:0];

  always_comb begin
    state_d = state_q; ei_d = ei_q; layer_d = layer_q; cn_d = cn_q; cc_d = cc_q;
    changed_d = changed_q; best_d = best_q; from_d = from_q; ok_d = ok_q;
    we = 1'b0; waddr = '0; wdata = Inf; raddr = '0;
    case (state_q)
      cbsp_pkg::StLoad: begin
        ei_d = '0;
        if (in_acc && in_data_i.last_edge) begin
          state_d = cbsp_pkg::StClear; cn_d = '0; cc_d = '0;
        end
      end
      cbsp_pkg::StClear: begin
        we = 1'b1; waddr = {cn_q[NW-1:0], cc_q[CW-1:0]};
        wdata = (cn_q == '0 && cc_q == '0) ? '0 : Inf;
        if (cc_q == (CW+1)'(mc_eff)) begin
          cc_d = '0; cn_d = cn_q + 1'b1;
          if (cn_q + 1'b1 == n_eff) begin
            state_d = cbsp_pkg::StZeroRd; layer_d = '0; ei_d = '0; changed_d = 1'b0;
          end
        end else cc_d = cc_q + 1'b1;
      end
      cbsp_pkg::StZeroRd, cbsp_pkg::StPosRd: begin
        // edge_rd_q holds edge ei_q; read source entry
        ok_d = e_good && ((state_q == cbsp_pkg::StZeroRd) ? (edge_rd_q.cost == '0)
               : (edge_rd_q.cost != '0 && nc <= NCW'(mc_eff)));
        raddr = {sidx, layer_q};
        if (ei_q == loaded_q) ok_d = 1'b0;
        state_d = (state_q == cbsp_pkg::StZeroRd) ? cbsp_pkg::StZeroWb : cbsp_pkg::StPosWb;
      end
      cbsp_pkg::StZeroWb, cbsp_pkg::StPosWb: begin
        // with ok set, latch source and read dest
        if (ok_q) begin
          from_d = rdata; ok_d = 1'b0; best_d = '0;
          raddr = {didx, (state_q == cbsp_pkg::StZeroWb) ? layer_q : nc[CW-1:0]};
          // ok is cleared and cc_q set to one marks the pending write-back:
          ei_d = ei_q; changed_d = changed_q;
          state_d = state_q; cc_d = (CW+1)'(1);
        end else if (cc_q == (CW+1)'(1)) begin
          cc_d = '0;
          waddr = {didx, (state_q == cbsp_pkg::StZeroWb) ? layer_q : nc[CW-1:0]};
          if (from_q != Inf && cand < rdata) begin
            we = 1'b1; wdata = cand;
            if (state_q == cbsp_pkg::StZeroWb) changed_d = 1'b1;
          end
          ei_d = ei_q + 1'b1;
          state_d = (state_q == cbsp_pkg::StZeroWb) ? cbsp_pkg::StZeroRd : cbsp_pkg::StPosRd;
        end else begin
          ei_d = ei_q + 1'b1;
          state_d = (state_q == cbsp_pkg::StZeroWb) ? cbsp_pkg::StZeroRd : cbsp_pkg::StPosRd;
        end
        if (cc_q != (CW+1)'(1) && !ok_q && ei_q >= loaded_q) begin
          ei_d = '0;
          if (state_q == cbsp_pkg::StZeroWb) begin
            if (changed_q) begin changed_d = 1'b0; state_d = cbsp_pkg::StZeroRd; end
            else state_d = cbsp_pkg::StPosRd;
          end else if (layer_q == mc_eff) begin
            state_d = cbsp_pkg::StScanRd; cc_d = '0; best_d = Inf;
          end else begin
            layer_d = layer_q + 1'b1; changed_d = 1'b0; state_d = cbsp_pkg::StZeroRd;
          end
        end
      end
      cbsp_pkg::StScanRd: begin
        raddr = {NW'(n_eff - 1'b1), cc_q[CW-1:0]};
        state_d = cbsp_pkg::StScanWb;
      end
      cbsp_pkg::StScanWb: begin
        if (rdata < best_q) best_d = rdata;
        if (cc_q == (CW+1)'(mc_eff)) state_d = cbsp_pkg::StOut;
        else begin cc_d = cc_q + 1'b1; state_d = cbsp_pkg::StScanRd; end
      end
      cbsp_pkg::StOut: state_d = cbsp_pkg::StLoad;
      default: state_d = cbsp_pkg::StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbsp_pkg::StLoad;
      node_count_q <= 8'd1; cost_bound_q <= '0;
      loaded_q <= '0; ovf_q <= 1'b0; out_valid_q <= 1'b0;
      ei_q <= '0; layer_q <= '0; cn_q <= '0; cc_q <= '0;
      changed_q <= 1'b0; ok_q <= 1'b0;
    end else begin
      state_q <= state_d; ei_q <= ei_d; layer_q <= layer_d; cn_q <= cn_d;
      cc_q <= cc_d; changed_q <= changed_d; ok_q <= ok_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == cbsp_pkg::CfgNodeCount) node_count_q <= cfg_data_i[7:0];
        else cost_bound_q <= cfg_data_i;
      end
      if (in_acc && in_data_i.edge_present) begin
        if (loaded_q < (EW+1)'(MAX_EDGES)) loaded_q <= loaded_q + 1'b1;
        else ovf_q <= 1'b1;
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == cbsp_pkg::StOut) begin
        out_valid_q <= 1'b1; loaded_q <= '0; ovf_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d; from_q <= from_d;
    if (state_q == cbsp_pkg::StOut) begin
      out_q.reachable     <= (best_q != Inf);
      out_q.min_distance  <= (best_q == Inf) ? 17'd0 :
                             (best_q > DW'(cbsp_pkg::DistSat)) ? cbsp_pkg::DistSat
                             : best_q[16:0];
      out_q.edge_overflow <= ovf_q;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != cbsp_pkg::StLoad) |-> in_stall_o) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result dropped");
  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= (EW+1)'(MAX_EDGES)) else $error("edge count overrun");

endmodule

// ===== bench/cbsp_checker.sv =====
// ----------------------------------------------------------------------------
// cbsp_checker
// Watches the edge, result and register channels of the cost-bounded
// shortest path block. It keeps its own copy of the loaded graph and the
// registers, predicts the result of each graph, and compares it with the result item.
// ----------------------------------------------------------------------------
module cbsp_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  cbsp_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  cbsp_pkg::out_item_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic                cfg_index_i,
  input  logic [9:0]          cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  graphs_done_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Inf = 32'hFFFF_FFFF;

  cbsp_pkg::in_item_t  graph_edges[$];
  bit                  dropped_edge;
  logic [7:0]          node_count_q;
  logic [9:0]          cost_bound_q;
  cbsp_pkg::out_item_t expected_results[$];
  int unsigned         best_dist[cbsp_pkg::MaxNodes][cbsp_pkg::CostLimit];

  assign pending_o = expected_results.size();

  // Layered relaxation: zero-cost edges to a fixpoint inside a layer,
  // positive-cost edges push into higher layers.
  function automatic cbsp_pkg::out_item_t solve_graph();
    int unsigned n, mc, s, d, nc, cand, sol;
    bit          changed;
    cbsp_pkg::out_item_t res;
    n = (node_count_q == 0) ? 1 :
        ((node_count_q > cbsp_pkg::MaxNodes) ? cbsp_pkg::MaxNodes : node_count_q);
    mc = (cost_bound_q >= cbsp_pkg::CostLimit) ? cbsp_pkg::CostLimit - 1 : cost_bound_q;
    for (int v = 0; v < n; v++)
      for (int c = 0; c <= mc; c++) best_dist[v][c] = Inf;
    best_dist[0][0] = 0;
    for (int c = 0; c <= mc; c++) begin
      do begin
        changed = 0;
        foreach (graph_edges[i]) begin
          s = graph_edges[i].src_node;
          d = graph_edges[i].dst_node;
          if (graph_edges[i].edge_cost != 0 || s < 1 || s > n || d < 1 || d > n) continue;
          if (best_dist[s-1][c] == Inf) continue;
          cand = best_dist[s-1][c] + graph_edges[i].edge_dist;
          if (cand < best_dist[d-1][c]) begin
            best_dist[d-1][c] = cand;
            changed = 1;
          end
        end
      end while (changed);
      foreach (graph_edges[i]) begin
        s = graph_edges[i].src_node;
        d = graph_edges[i].dst_node;
        if (graph_edges[i].edge_cost == 0 || s < 1 || s > n || d < 1 || d > n) continue;
        nc = c + graph_edges[i].edge_cost;
        if (nc > mc || best_dist[s-1][c] == Inf) continue;
        cand = best_dist[s-1][c] + graph_edges[i].edge_dist;
        if (cand < best_dist[d-1][nc]) best_dist[d-1][nc] = cand;
      end
    end
    sol = Inf;
    for (int c = 0; c <= mc; c++)
      if (best_dist[n-1][c] < sol) sol = best_dist[n-1][c];
    res.reachable     = (sol != Inf);
    res.min_distance  = (sol == Inf) ? 17'd0 :
                        ((sol > cbsp_pkg::DistSat) ? cbsp_pkg::DistSat : sol[16:0]);
    res.edge_overflow = dropped_edge;
    return res;
  endfunction

  always @(posedge clk_i) begin
    cbsp_pkg::out_item_t want;
    if (!rst_ni) begin
      fail_count_o  <= 0;
      graphs_done_o <= 0;
      dropped_edge  = 0;
      node_count_q  <= 8'd1;
      cost_bound_q  <= 10'd0;
      graph_edges.delete();
      expected_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == cbsp_pkg::CfgNodeCount) node_count_q <= cfg_data_i[7:0];
        else                                       cost_bound_q <= cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.edge_present) begin
          if (graph_edges.size() < cbsp_pkg::MaxEdges)
            graph_edges.insert(graph_edges.size(), in_data_i);
          else dropped_edge = 1;
        end
        if (in_data_i.last_edge) begin
          expected_results.insert(expected_results.size(), solve_graph());
          graph_edges.delete();
          dropped_edge = 0;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        graphs_done_o <= graphs_done_o + 1;
        if (expected_results.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10)
            $display("ERROR: unexpected result %p", out_data_i);
        end else begin
          want = expected_results.pop_front();
          if (want !== out_data_i) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("ERROR: result mismatch, expected %p, got %p", want, out_data_i);
          end
        end
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the cost-bounded shortest path block: directed
// graphs for the corner cases, then random graphs under changing register
// settings and three idling patterns, checked by cbsp_checker.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 1000000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  cbsp_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall = 1'b0;
  cbsp_pkg::out_item_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_index;
  logic [9:0]          cfg_data;
  int                  fail_count, pending, graphs_done;
  int                  tx_pct, rx_pct, items_sent;
  int                  idle_cycles = 0;

  cost_bounded_shortest_path i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  cbsp_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .graphs_done_o(graphs_done)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_pct);
  end

  // no-progress watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_item(input cbsp_pkg::in_item_t it);
    bit took;
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [9:0] val);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [9:0] nodes, input logic [9:0] cost_bound);
    drain();
    write_reg(cbsp_pkg::CfgNodeCount, nodes);
    write_reg(cbsp_pkg::CfgMaxCost, cost_bound);
  endtask

  function automatic cbsp_pkg::in_item_t mk_edge(input int s, input int d, input int c,
                                                 input int w, input bit last);
    cbsp_pkg::in_item_t it;
    it.edge_present = 1'b1;
    it.src_node     = s[7:0];
    it.dst_node     = d[7:0];
    it.edge_cost    = c[9:0];
    it.edge_dist    = w[9:0];
    it.last_edge    = last;
    return it;
  endfunction

  function automatic int pick_node(input int n);
    int r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(1, n);
    if (r < 92) return 0;
    return $urandom_range(0, 255);
  endfunction

  function automatic cbsp_pkg::in_item_t rand_edge(input int n);
    cbsp_pkg::in_item_t it;
    int s, d, c, w;
    s = pick_node(n);
    d = ($urandom_range(1) && s >= 1 && s < n) ? s + 1 : pick_node(n);
    case ($urandom_range(3))
      0:       c = 0;
      1, 2:    c = $urandom_range(1, 3);
      default: c = $urandom_range(0, 1023);
    endcase
    w = ($urandom_range(99) < 60) ? $urandom_range(0, 20) : $urandom_range(0, 1023);
    it = mk_edge(s, d, c, w, 1'b0);
    return it;
  endfunction

  task automatic rand_graph(input int n, input int nedges);
    cbsp_pkg::in_item_t it;
    for (int i = 0; i < nedges; i++) begin
      if ($urandom_range(99) < 5) begin
        it = rand_edge(n);
        it.edge_present = 1'b0;
        send_item(it);
        items_sent--;   // ignored marker, not counted
      end
      send_item(rand_edge(n));
    end
    it = rand_edge(n);
    it.edge_present = 1'($urandom_range(1));
    it.last_edge    = 1'b1;
    send_item(it);
  endtask

  task automatic random_phase(input int quota);
    int stop_at, n;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 12) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 10);
        set_regs(10'(n | ($urandom_range(3) << 8)), 10'($urandom_range(0, 12)));
      end else if ($urandom_range(99) < 5) begin
        drain();
      end
      rand_graph(8, $urandom_range(0, 10));
    end
  endtask

  initial begin
    cbsp_pkg::in_item_t it;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = cbsp_pkg::CfgNodeCount;
    cfg_data  = '0;
    tx_pct = 27;
    rx_pct = 69;
    items_sent  = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // single node at reset settings: bare end marker
    it = '0;
    it.last_edge = 1'b1;
    send_item(it);
    // node count zero counts as one
    set_regs(10'd0, 10'd0);
    send_item(mk_edge(1, 1, 0, 5, 1'b1));
    // chain with a zero-cost cycle, cost bound of 4
    set_regs(10'd4, 10'd4);
    send_item(mk_edge(1, 2, 0, 1023, 1'b0));
    send_item(mk_edge(2, 1, 0, 0, 1'b0));
    send_item(mk_edge(2, 3, 2, 7, 1'b0));
    send_item(mk_edge(1, 3, 1023, 1, 1'b0));
    send_item(mk_edge(3, 4, 2, 1, 1'b0));
    send_item(mk_edge(1, 4, 5, 0, 1'b1));
    // bound too tight: unreachable; bad node numbers ignored
    set_regs(10'd3, 10'd1);
    send_item(mk_edge(0, 3, 0, 0, 1'b0));
    send_item(mk_edge(1, 255, 0, 0, 1'b0));
    send_item(mk_edge(4, 3, 0, 0, 1'b0));
    send_item(mk_edge(1, 2, 1, 3, 1'b0));
    send_item(mk_edge(2, 3, 1, 3, 1'b1));
    // node count above the maximum, largest cost bound
    set_regs(10'd1023, 10'd1023);
    send_item(mk_edge(1, 128, 1023, 1023, 1'b0));
    send_item(mk_edge(1, 64, 512, 0, 1'b0));
    it = mk_edge(64, 128, 511, 2, 1'b1);
    it.edge_present = 1'b0;
    send_item(it);
    set_regs(10'd128, 10'd1022);
    send_item(mk_edge(1, 64, 512, 0, 1'b0));
    send_item(mk_edge(64, 128, 511, 2, 1'b1));

    random_phase(260);
    tx_pct = 69;
    rx_pct = 27;
    random_phase(260);
    tx_pct = 0;
    rx_pct = 0;
    random_phase(260);

    drain();
    repeat (20) @(posedge clk);
    $display("Ran %0d edge items, %0d graphs checked, under three idling patterns.",
             items_sent, graphs_done);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
